@@ hw/rtl/sttf_pkg.sv @@
// Shared types, codes and constants for the string tension force block.
package sttf_pkg;

  localparam logic signed [15:0] THRESH_RESET = 16'sd16220;
  localparam int                 SUM_W        = 40;
  localparam int                 SHORT_W      = 41;
  localparam int                 FORCE_N      = 6;
  localparam int                 IDX_W        = 3;
  localparam logic [IDX_W-1:0]   B_SIDE_IDX   = 3'd3;
  localparam logic [IDX_W-1:0]   LAST_IDX     = 3'd6;

  typedef struct packed {
    logic signed [31:0] segment_length;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] rest_length;
    logic        [31:0] stiffness;
    logic               last_segment;
  } sttf_in_t;

  typedef struct packed {
    logic               tension_active;
    logic        [31:0] tension;
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_a_z;
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic signed [31:0] force_b_z;
  } sttf_out_t;

  typedef enum logic [1:0] {
    MSEL_LO,
    MSEL_HI,
    MSEL_FORCE
  } sttf_msel_t;

  typedef struct packed {
    logic             accept;
    logic             setup;
    logic             mul_en;
    sttf_msel_t       mul_sel;
    logic [IDX_W-1:0] mul_idx;
    logic             save_acc;
    logic             load_tension;
    logic             store_en;
    logic [IDX_W-1:0] store_idx;
    logic             load_out;
  } sttf_cmd_t;

  typedef struct packed {
    logic in_last;
  } sttf_sts_t;

endpackage

@@ hw/rtl/sttf_dp.sv @@
// Datapath: length sum, straightness check, shared multiplier, tension and end forces.
module sttf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sttf_pkg::sttf_in_t  in_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  sttf_pkg::sttf_cmd_t cmd,
  output sttf_pkg::sttf_sts_t sts,
  output sttf_pkg::sttf_out_t out_data
);

  localparam int IDX_W = sttf_pkg::IDX_W;

  logic signed [15:0] thresh_r;
  logic signed [39:0] length_sum_r, length_sum_nxt;
  logic signed [15:0] first_n_r [3];
  logic signed [15:0] prev_n_r  [3];
  logic               straight_ok_r, straight_ok_nxt;
  logic               at_start_r;
  logic signed [31:0] rest_r;
  logic        [31:0] stiff_r;
  logic               active_r;
  logic [40:0]        shortfall_r;
  logic [63:0]        prod_r;
  logic [63:0]        acc_r;
  logic [31:0]        tension_r, tension_nxt;
  logic [31:0]        force_r [sttf_pkg::FORCE_N];
  logic [31:0]        force_nxt;
  sttf_pkg::sttf_out_t out_r;

  logic signed [15:0] in_n [3];
  logic signed [33:0] dot;
  logic signed [33:0] thr_scaled;
  logic signed [40:0] sum_ext;
  logic signed [40:0] diff;
  logic [31:0]        mul_a, mul_b;
  logic signed [15:0] mul_n, store_n;
  logic [16:0]        mul_n_neg;
  logic [15:0]        mul_n_mag;
  logic [41:0]        upper;
  logic [32:0]        q;
  logic               store_neg;

  assign in_n[0] = in_data.normal_x;
  assign in_n[1] = in_data.normal_y;
  assign in_n[2] = in_data.normal_z;

  assign sts.in_last = in_data.last_segment;

  always_comb begin
    dot = 34'(prev_n_r[0] * in_n[0]) + 34'(prev_n_r[1] * in_n[1])
        + 34'(prev_n_r[2] * in_n[2]);
    thr_scaled = {{4{thresh_r[15]}}, thresh_r, 14'b0};
    sum_ext = {length_sum_r[39], length_sum_r}
            + {{9{in_data.segment_length[31]}}, in_data.segment_length};
    if (at_start_r) begin
      length_sum_nxt  = {{8{in_data.segment_length[31]}}, in_data.segment_length};
      straight_ok_nxt = 1'b1;
    end else begin
      if (sum_ext[40] != sum_ext[39]) begin
        length_sum_nxt = sum_ext[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
      end else begin
        length_sum_nxt = sum_ext[39:0];
      end
      straight_ok_nxt = straight_ok_r && !(dot < thr_scaled);
    end
  end

  assign diff = {length_sum_r[39], length_sum_r} - {{9{rest_r[31]}}, rest_r};

  always_comb begin
    case (cmd.mul_idx)
      3'd0:    mul_n = first_n_r[0];
      3'd1:    mul_n = first_n_r[1];
      3'd2:    mul_n = first_n_r[2];
      3'd3:    mul_n = prev_n_r[0];
      3'd4:    mul_n = prev_n_r[1];
      3'd5:    mul_n = prev_n_r[2];
      default: mul_n = '0;
    endcase
    case (cmd.store_idx)
      3'd0:    store_n = first_n_r[0];
      3'd1:    store_n = first_n_r[1];
      3'd2:    store_n = first_n_r[2];
      3'd3:    store_n = prev_n_r[0];
      3'd4:    store_n = prev_n_r[1];
      3'd5:    store_n = prev_n_r[2];
      default: store_n = '0;
    endcase
    mul_n_neg = -{mul_n[15], mul_n};
    mul_n_mag = mul_n[15] ? mul_n_neg[15:0] : mul_n;
    case (cmd.mul_sel)
      sttf_pkg::MSEL_LO: begin
        mul_a = stiff_r;
        mul_b = shortfall_r[31:0];
      end
      sttf_pkg::MSEL_HI: begin
        mul_a = stiff_r;
        mul_b = {23'b0, shortfall_r[40:32]};
      end
      sttf_pkg::MSEL_FORCE: begin
        mul_a = tension_r;
        mul_b = {16'b0, mul_n_mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    upper = {10'b0, acc_r[63:32]} + {1'b0, prod_r[40:0]};
    if (!active_r) begin
      tension_nxt = '0;
    end else if (upper[41:16] != '0) begin
      tension_nxt = '1;
    end else begin
      tension_nxt = {upper[15:0], acc_r[31:16]};
    end
    q = prod_r[46:14];
    store_neg = store_n[15] ^ (cmd.store_idx >= sttf_pkg::B_SIDE_IDX);
    if (store_neg) begin
      force_nxt = (q > 33'h080000000) ? 32'h80000000 : -q[31:0];
    end else begin
      force_nxt = (q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= sttf_pkg::THRESH_RESET;
      length_sum_r  <= '0;
      straight_ok_r <= 1'b1;
      at_start_r    <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        first_n_r[i] <= '0;
        prev_n_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        length_sum_r  <= length_sum_nxt;
        straight_ok_r <= straight_ok_nxt;
        at_start_r    <= in_data.last_segment;
        for (int i = 0; i < 3; i++) begin
          prev_n_r[i] <= in_n[i];
          if (at_start_r) begin
            first_n_r[i] <= in_n[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.last_segment) begin
      rest_r  <= in_data.rest_length;
      stiff_r <= in_data.stiffness;
    end
    if (cmd.setup) begin
      active_r    <= diff[40] && straight_ok_r;
      shortfall_r <= -diff;
    end
    if (cmd.save_acc) begin
      acc_r <= prod_r;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.load_tension) begin
      tension_r <= tension_nxt;
    end
    for (int i = 0; i < sttf_pkg::FORCE_N; i++) begin
      if (cmd.store_en && (cmd.store_idx == IDX_W'(i))) begin
        force_r[i] <= force_nxt;
      end
    end
    if (cmd.load_out) begin
      out_r.tension_active <= active_r;
      out_r.tension        <= tension_r;
      out_r.force_a_x      <= force_r[0];
      out_r.force_a_y      <= force_r[1];
      out_r.force_a_z      <= force_r[2];
      out_r.force_b_x      <= force_r[3];
      out_r.force_b_y      <= force_r[4];
      out_r.force_b_z      <= force_r[5];
    end
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/sttf_ctrl.sv @@
// Controller: segment intake, result sequence over the shared multiplier, output handshake.
module sttf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sttf_pkg::sttf_sts_t sts,
  output sttf_pkg::sttf_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_FORCE,
    ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [sttf_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_sel   = sttf_pkg::MSEL_LO;
    cmd.accept    = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.in_last) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sttf_pkg::MSEL_LO;
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = sttf_pkg::MSEL_HI;
        cmd.save_acc = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.load_tension = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = ST_FORCE;
      end
      ST_FORCE: begin
        cmd.mul_sel   = sttf_pkg::MSEL_FORCE;
        cmd.mul_idx   = cnt_r;
        cmd.mul_en    = (cnt_r != sttf_pkg::LAST_IDX);
        cmd.store_en  = (cnt_r != '0);
        cmd.store_idx = cnt_r - 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == sttf_pkg::LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/string_tension_force.sv @@
// Top level of the string tension force block.
// Segments of a string arrive one per transfer; a segment that is not the last
// is taken without stalling the input, so a string streams at one segment per
// cycle. The last segment starts the result sequence, which runs with the input
// stalled: a setup state, two passes of the shared 32x32 multiplier for
// stiffness times shortfall, a saturation state, a force state that runs the
// six end-force products through the same multiplier, and a state that loads
// the output register. The load state, and with it the input stall, lasts for as
// long as the output register still holds an earlier result that is stalled.
// The result then waits in the output register while the next string's segments
// are taken. The threshold register may be written at any time the block is idle.
module string_tension_force (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sttf_pkg::sttf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sttf_pkg::sttf_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  sttf_pkg::sttf_cmd_t cmd;
  sttf_pkg::sttf_sts_t sts;

  sttf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sttf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
